// ===== design/seou_pkg.sv =====
// Shared types, codes and helper functions for the shifted/extended operand unit.
// Used by seou_shift and shifted_extended_operand_unit; depends on nothing else.
package seou_pkg;

  typedef enum logic [1:0] {
    EXT_NONE = 2'd0,
    EXT_SIGN = 2'd1,
    EXT_ZERO = 2'd2
  } extend_mode_t;

  typedef enum logic [2:0] {
    SH_NONE     = 3'd0,
    SH_LSL      = 3'd1,
    SH_LSL_ONES = 3'd2,
    SH_LSR      = 3'd3,
    SH_ASR      = 3'd4,
    SH_ROL      = 3'd5,
    SH_ROR      = 3'd6
  } shift_mode_t;

  localparam int unsigned ValueBits = 64;
  localparam int unsigned WidthBits = 7;
  localparam int unsigned AmountBits = 6;

  // One word after trimming and extension, on its way into the shifter.
  typedef struct packed {
    logic [ValueBits-1:0]  value;
    logic [WidthBits-1:0]  operand_bits;
    shift_mode_t           mode;
    logic [AmountBits-1:0] amount;
  } opnd_t;

  // Widths above 64 behave as 64.
  function automatic logic [WidthBits-1:0] cap64(input logic [WidthBits-1:0] x);
    logic [WidthBits-1:0] r;
    r = (x > 7'd64) ? 7'd64 : x;
    return r;
  endfunction

  // Ones in the low b bits; zero width gives zero, 64 and up gives all ones.
  function automatic logic [ValueBits-1:0] low_mask(input logic [WidthBits-1:0] b);
    logic [ValueBits-1:0] m;
    if (b >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << b[5:0]) - 64'd1;
    end
    return m;
  endfunction

  // Sign-extend from bit b-1; a width of zero or 64 and up leaves the value alone.
  function automatic logic [ValueBits-1:0] sign_from(input logic [ValueBits-1:0] v,
                                                     input logic [WidthBits-1:0] b);
    logic [ValueBits-1:0]  m;
    logic [ValueBits-1:0]  vl;
    logic [ValueBits-1:0]  r;
    logic [AmountBits-1:0] top;
    m = low_mask(b);
    vl = v & m;
    top = AmountBits'(b - 7'd1);
    if (b == 7'd0 || b >= 7'd64) begin
      r = v;
    end else if (vl[top]) begin
      r = vl | ~m;
    end else begin
      r = vl;
    end
    return r;
  endfunction

endpackage

// ===== design/seou_shift.sv =====
// Shift and rotate core of the operand unit: all six shift modes on one word.
// Depends on seou_pkg for the word type, shift codes and sign extension.
module seou_shift (
  input  seou_pkg::opnd_t                 opnd,
  output logic [seou_pkg::ValueBits-1:0]  shifted_value,
  output logic                            is_shift
);

  logic [seou_pkg::AmountBits-1:0] back;
  logic [seou_pkg::ValueBits-1:0]  v;
  logic [seou_pkg::ValueBits-1:0]  t;
  logic signed [seou_pkg::ValueBits-1:0] ts;

  // The reverse rotate distance wraps within the operand width; a zero width
  // leaves the low six bits of the mask all ones.
  always_comb begin
    back = (seou_pkg::AmountBits'(0) - opnd.amount)
           & seou_pkg::AmountBits'(opnd.operand_bits - 7'd1);
  end

  always_comb begin
    v = opnd.value;
    t = seou_pkg::sign_from(v, opnd.operand_bits);
    ts = $signed(t) >>> opnd.amount;
    shifted_value = v;
    is_shift = 1'b1;
    case (opnd.mode)
      seou_pkg::SH_LSL:      shifted_value = v << opnd.amount;
      seou_pkg::SH_LSL_ONES: shifted_value = (v << opnd.amount) | ~(~64'd0 << opnd.amount);
      seou_pkg::SH_LSR:      shifted_value = v >> opnd.amount;
      seou_pkg::SH_ASR:      shifted_value = ts;
      seou_pkg::SH_ROL:      shifted_value = (v >> back) | (v << opnd.amount);
      seou_pkg::SH_ROR:      shifted_value = (v >> opnd.amount) | (v << back);
      default: begin
        shifted_value = v;
        is_shift = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/shifted_extended_operand_unit.sv =====
// Shifted/extended operand unit: three register stages (trim and extend, shift, mask).
// Throughput is one word per clock while the output is not stalled; each stage holds one
// word and moves on whenever the stage after it is free or draining, so a stalled output
// holds all earlier words.
// Synchronous reset clears the stage valid bits only; the data registers are not reset.
// Depends on seou_pkg and seou_shift.
module shifted_extended_operand_unit #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [63:0] reg_value,
  input  logic [6:0]  reg_bits,
  input  logic [1:0]  extend_mode,
  input  logic [6:0]  extract_bits,
  input  logic [6:0]  operand_bits,
  input  logic [2:0]  shift_mode,
  input  logic [5:0]  shift_amount,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [63:0] operand_value
);

  logic en1;
  logic en2;
  logic en3;

  logic            v1;
  seou_pkg::opnd_t st1;
  seou_pkg::opnd_t st1_next;

  logic        v2;
  logic [63:0] val2;
  logic [6:0]  ob2;
  logic        need_mask2;

  logic [63:0] shifted_value;
  logic        is_shift;

  logic [6:0]  rb;
  logic [6:0]  eb;
  logic [6:0]  ob;
  logic [6:0]  trim_bits;
  logic [6:0]  cur;
  logic [63:0] v;

  assign en3 = !result_valid || result_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign item_ready = en1;

  // Stage one: trim to whole bytes; if an extend mode is set, cut to the extract width and
  // extend; then mask to the width in use if that is still below the operand width.
  always_comb begin
    rb = seou_pkg::cap64(reg_bits);
    eb = seou_pkg::cap64(extract_bits);
    ob = seou_pkg::cap64(operand_bits);
    trim_bits = ((rb + 7'd7) >> 3) << 3;
    v = reg_value & seou_pkg::low_mask(trim_bits);
    cur = rb;
    if (extend_mode != seou_pkg::EXT_NONE) begin
      if (rb > eb) begin
        cur = eb;
        v = v & seou_pkg::low_mask(eb);
      end
      if (ob > eb) begin
        if (extend_mode == seou_pkg::EXT_SIGN) begin
          v = seou_pkg::sign_from(v, eb);
        end
        cur = ob;
      end
    end
    if (cur < ob) begin
      v = v & seou_pkg::low_mask(cur);
    end
    st1_next.value = v;
    st1_next.operand_bits = ob;
    st1_next.mode = seou_pkg::shift_mode_t'(shift_mode);
    st1_next.amount = shift_amount;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && item_valid) begin
      st1 <= st1_next;
    end
  end

  // Stage two: the shifter.
  seou_shift u_shift (
    .opnd          (st1),
    .shifted_value (shifted_value),
    .is_shift      (is_shift)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      val2 <= shifted_value;
      ob2 <= st1.operand_bits;
      need_mask2 <= is_shift || (7'(WORD_BITS) > st1.operand_bits);
    end
  end

  // Stage three: clear everything above the operand width and hold the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en3) begin
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      operand_value <= need_mask2 ? (val2 & seou_pkg::low_mask(ob2)) : val2;
    end
  end

`ifndef ASSERT_OFF
  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && result_valid && !result_ready) |-> !item_ready)
    else $error("input accepted while every stage is full and the output stalls");

  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    (v1 && !en2) |=> (v1 && $stable(st1)))
    else $error("stage one word lost or changed during a stall");

  a_result_masked: assert property (@(posedge clk) disable iff (rst)
    (v2 && en3 && need_mask2) |=>
      ((operand_value & ~seou_pkg::low_mask($past(ob2))) == 64'd0))
    else $error("result has bits set above the operand width");
`endif

endmodule
